@@ hdl/segint_pkg.sv @@
`default_nettype none
package segint_pkg;
    localparam int CB = 16;          // coordinate bits
    localparam int DW = CB + 1;      // delta width, signed
    localparam int PW = 2 * DW + 1;  // cross product / numerator width
    localparam int QW = DW;          // quotient width (quotient <= |delta|)
    localparam int NW = PW + QW;     // dividend width
    typedef logic signed [CB-1:0] coord_t;
    typedef logic signed [DW-1:0] delta_t;
    typedef logic signed [PW-1:0] cross_t;
endpackage
`default_nettype wire

@@ hdl/segment_intersection.sv @@
`default_nettype none
// Segment intersection test, fully pipelined.
// Input channel (in_valid/in_ready): one beat carries both segments, A from
// (a_start_x,a_start_y) to (a_end_x,a_end_y) and B likewise, signed coords.
// Output channel (out_valid/out_ready): one beat per input beat, in order,
// with hit and the point on A (zero on a miss or parallel segments).
// Throughput: one beat per cycle while the output is not stalled. Pipeline:
// 6 front stages for deltas, products, cross sums, sign fold, range test
// and scaling multiply; 17 stages of the restoring divider, one quotient
// bit each; one output register. The divider length equals the quotient
// width, which is the coordinate width plus one.
// Reset clears every valid bit; payload registers are not reset.
// When the receiver stalls with a beat waiting, the whole pipeline holds,
// in_ready drops in the same cycle, and nothing is lost or repeated.
// Bubbles move up as soon as the output beat is taken.
module segment_intersection (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire segint_pkg::coord_t  a_start_x,
    input  wire segint_pkg::coord_t  a_start_y,
    input  wire segint_pkg::coord_t  a_end_x,
    input  wire segint_pkg::coord_t  a_end_y,
    input  wire segint_pkg::coord_t  b_start_x,
    input  wire segint_pkg::coord_t  b_start_y,
    input  wire segint_pkg::coord_t  b_end_x,
    input  wire segint_pkg::coord_t  b_end_y,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic                     hit,
    output segint_pkg::coord_t       hit_x,
    output segint_pkg::coord_t       hit_y
);
    import segint_pkg::*;

    localparam int FRONT = 6;

    typedef struct packed {
        coord_t sx;
        coord_t sy;
        logic   negx;
        logic   negy;
        logic   hit;
    } side_t;

    logic advance;
    logic [FRONT-1:0] fv_reg;
    logic [QW-1:0]    dv_reg;
    logic             ov_reg;

    // stall everything while an output beat waits
    assign advance  = !ov_reg || out_ready;
    assign in_ready = advance;

    // stage 1: deltas
    delta_t adx_reg, ady_reg, bdx_reg, bdy_reg, ox_reg, oy_reg;
    coord_t sx1_reg, sy1_reg;
    // stage 2: products
    logic signed [2*DW-1:0] p_den0_reg, p_den1_reg, p_na0_reg, p_na1_reg;
    logic signed [2*DW-1:0] p_nb0_reg, p_nb1_reg;
    delta_t adx2_reg, ady2_reg;
    coord_t sx2_reg, sy2_reg;
    // stage 3: cross sums
    cross_t den3_reg, na3_reg, nb3_reg;
    delta_t adx3_reg, ady3_reg;
    coord_t sx3_reg, sy3_reg;
    // stage 4: sign fold
    cross_t den4_reg, na4_reg, nb4_reg;
    logic [DW-1:0] magx4_reg, magy4_reg;
    side_t  sb4_reg;
    // stage 5: range test
    logic [PW-1:0] den5_reg, na5_reg;
    logic [DW-1:0] magx5_reg, magy5_reg;
    side_t  sb5_reg;
    // stage 6: scaling multiply
    logic [NW-1:0] numx6_reg, numy6_reg;
    logic [PW-1:0] den6_reg;
    side_t  sb6_reg;
    // divider sideband and output
    side_t  sbd_reg [QW];
    logic   hit_reg;
    coord_t hx_reg, hy_reg;

    logic [QW-1:0] qx, qy;
    logic signed [DW:0] hx_full, hy_full;

    function automatic delta_t sub_c(input coord_t a, input coord_t b);
        sub_c = $signed({a[CB-1], a}) - $signed({b[CB-1], b});
    endfunction

    function automatic cross_t sub_p(input logic signed [2*DW-1:0] a,
                                     input logic signed [2*DW-1:0] b);
        sub_p = $signed({a[2*DW-1], a}) - $signed({b[2*DW-1], b});
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fv_reg <= '0;
            dv_reg <= '0;
            ov_reg <= 1'b0;
        end
        else if (advance)
        begin
            fv_reg <= {fv_reg[FRONT-2:0], in_valid};
            dv_reg <= {dv_reg[QW-2:0], fv_reg[FRONT-1]};
            ov_reg <= dv_reg[QW-1];
        end
    end

    logic neg4;
    assign neg4 = den3_reg[PW-1];

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            adx_reg <= sub_c(a_end_x, a_start_x);
            ady_reg <= sub_c(a_end_y, a_start_y);
            bdx_reg <= sub_c(b_end_x, b_start_x);
            bdy_reg <= sub_c(b_end_y, b_start_y);
            ox_reg  <= sub_c(a_start_x, b_start_x);
            oy_reg  <= sub_c(a_start_y, b_start_y);
            sx1_reg <= a_start_x;
            sy1_reg <= a_start_y;

            p_den0_reg <= bdy_reg * adx_reg;
            p_den1_reg <= bdx_reg * ady_reg;
            p_na0_reg  <= bdx_reg * oy_reg;
            p_na1_reg  <= bdy_reg * ox_reg;
            p_nb0_reg  <= adx_reg * oy_reg;
            p_nb1_reg  <= ady_reg * ox_reg;
            adx2_reg   <= adx_reg;
            ady2_reg   <= ady_reg;
            sx2_reg    <= sx1_reg;
            sy2_reg    <= sy1_reg;

            den3_reg <= sub_p(p_den0_reg, p_den1_reg);
            na3_reg  <= sub_p(p_na0_reg, p_na1_reg);
            nb3_reg  <= sub_p(p_nb0_reg, p_nb1_reg);
            adx3_reg <= adx2_reg;
            ady3_reg <= ady2_reg;
            sx3_reg  <= sx2_reg;
            sy3_reg  <= sy2_reg;

            // fold so the denominator is non-negative
            den4_reg  <= neg4 ? -den3_reg : den3_reg;
            na4_reg   <= neg4 ? -na3_reg : na3_reg;
            nb4_reg   <= neg4 ? -nb3_reg : nb3_reg;
            magx4_reg <= adx3_reg[DW-1] ? -adx3_reg : adx3_reg;
            magy4_reg <= ady3_reg[DW-1] ? -ady3_reg : ady3_reg;
            sb4_reg   <= '{sx: sx3_reg, sy: sy3_reg, negx: adx3_reg[DW-1],
                           negy: ady3_reg[DW-1], hit: 1'b0};

            den5_reg  <= den4_reg;
            na5_reg   <= na4_reg;
            magx5_reg <= magx4_reg;
            magy5_reg <= magy4_reg;
            sb5_reg   <= '{sx: sb4_reg.sx, sy: sb4_reg.sy, negx: sb4_reg.negx,
                           negy: sb4_reg.negy,
                           hit: (den4_reg != '0) && !na4_reg[PW-1]
                                && (na4_reg <= den4_reg)
                                && !nb4_reg[PW-1] && (nb4_reg <= den4_reg)};

            numx6_reg <= NW'(na5_reg) * NW'(magx5_reg);
            numy6_reg <= NW'(na5_reg) * NW'(magy5_reg);
            den6_reg  <= sb5_reg.hit ? den5_reg : PW'(1);
            sb6_reg   <= sb5_reg;

            for (int k = 0; k < QW; k++)
            begin
                sbd_reg[k] <= (k == 0) ? sb6_reg : sbd_reg[(k == 0) ? 0 : k - 1];
            end

            hit_reg <= sbd_reg[QW-1].hit;
            hx_reg  <= sbd_reg[QW-1].hit ? hx_full[CB-1:0] : '0;
            hy_reg  <= sbd_reg[QW-1].hit ? hy_full[CB-1:0] : '0;
        end
    end

    segint_div u_div_x (.clk(clk), .en(advance), .num(numx6_reg), .den(den6_reg), .quo(qx));
    segint_div u_div_y (.clk(clk), .en(advance), .num(numy6_reg), .den(den6_reg), .quo(qy));

    always_comb
    begin
        hx_full = sbd_reg[QW-1].negx
            ? $signed({{2{sbd_reg[QW-1].sx[CB-1]}}, sbd_reg[QW-1].sx}) - $signed({1'b0, qx})
            : $signed({{2{sbd_reg[QW-1].sx[CB-1]}}, sbd_reg[QW-1].sx}) + $signed({1'b0, qx});
        hy_full = sbd_reg[QW-1].negy
            ? $signed({{2{sbd_reg[QW-1].sy[CB-1]}}, sbd_reg[QW-1].sy}) - $signed({1'b0, qy})
            : $signed({{2{sbd_reg[QW-1].sy[CB-1]}}, sbd_reg[QW-1].sy}) + $signed({1'b0, qy});
    end

    assign out_valid = ov_reg;
    assign hit       = hit_reg;
    assign hit_x     = hx_reg;
    assign hit_y     = hy_reg;

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !hit) |-> (hit_x == '0 && hit_y == '0))
        else $error("miss with nonzero point");
    a_no_take_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !in_ready)
        else $error("input taken while output stalled");
    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> ($stable(fv_reg) && $stable(dv_reg)))
        else $error("pipeline moved during stall");
endmodule
`default_nettype wire

@@ hdl/segint_div.sv @@
`default_nettype none
module segint_div (
    input  wire logic                     clk,
    input  wire logic                     en,
    input  wire logic [segint_pkg::NW-1:0] num,
    input  wire logic [segint_pkg::PW-1:0] den,
    output logic      [segint_pkg::QW-1:0] quo
);
    import segint_pkg::*;

    // Restoring division, one quotient bit per stage. The quotient is known
    // to fit in QW bits, so the top PW bits of the dividend start below den.
    logic [PW-1:0] rem_reg  [QW];
    logic [QW-1:0] word_reg [QW];
    logic [PW-1:0] den_reg  [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [PW-1:0] rem_in;
        logic [QW-1:0] word_in;
        logic [PW-1:0] den_in;
        logic [PW:0]   trial;
        logic [PW:0]   diff;
        logic          ge;
        if (k == 0) begin : g_first
            assign rem_in  = num[NW-1:QW];
            assign word_in = num[QW-1:0];
            assign den_in  = den;
        end else begin : g_next
            assign rem_in  = rem_reg[k-1];
            assign word_in = word_reg[k-1];
            assign den_in  = den_reg[k-1];
        end
        assign trial = {rem_in, word_in[QW-1]};
        assign diff  = trial - {1'b0, den_in};
        assign ge    = trial >= {1'b0, den_in};
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= ge ? diff[PW-1:0] : trial[PW-1:0];
                word_reg[k] <= {word_in[QW-2:0], ge};
                den_reg[k]  <= den_in;
            end
        end
    end

    assign quo = word_reg[QW-1];
endmodule
`default_nettype wire
